// File: rtl/core/lbp_hist_pkg.sv
// ----------------------------------------------------------------------------
// LBP histogram package
// Shared types, codes, widths and constants of the LBP histogram core.
// ----------------------------------------------------------------------------
package lbp_hist_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int MIN_DIM        = 3;

	localparam int CFG_W      = 11;
	localparam int CFG_ADDR_W = 3;
	localparam int PDATA_W    = 32;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd1024;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd1024;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_sel_t;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	localparam int PIX_W     = 8;
	localparam int BIN_W     = 8;
	localparam int CNT_W     = 21;
	localparam int OUT_CNT_W = 20;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int SUM_W      = 15;
	localparam int GREY_SHIFT = 21;
	localparam logic [SUM_W-1:0] RED_WT     = 15'd30;
	localparam logic [SUM_W-1:0] GREEN_WT   = 15'd59;
	localparam logic [SUM_W-1:0] BLUE_WT    = 15'd11;
	localparam logic [SUM_W-1:0] GREY_RECIP = 15'd20972;

	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 8;

	typedef struct packed {
		cmd_t             cmd;
		logic [PIX_W-1:0] grey;
		logic             interior;
		logic [BIN_W-1:0] bin_index;
	} item_t;

	typedef struct packed {
		logic                 code_valid;
		logic [PIX_W-1:0]     lbp_code;
		logic [OUT_CNT_W-1:0] bin_count;
		logic [OUT_CNT_W-1:0] interior_count;
	} result_t;

	function automatic logic [OUT_CNT_W-1:0] sat_out(input logic [CNT_W-1:0] v);
		logic [OUT_CNT_W-1:0] r;
		r = v[CNT_W-1] ? '1 : v[OUT_CNT_W-1:0];
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = (v == CNT_MAX) ? v : v + CNT_W'(1);
		return r;
	endfunction

endpackage

// File: rtl/core/lbp_hist_front.sv
// ----------------------------------------------------------------------------
// LBP histogram front end
// Accepts beats, tracks the raster position, and computes the grey level.
// ----------------------------------------------------------------------------
module lbp_hist_front #(
	parameter int MAX_WIDTH  = lbp_hist_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lbp_hist_pkg::DEF_MAX_HEIGHT,
	parameter int COL_W      = $clog2(MAX_WIDTH),
	parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pix_valid,
	output logic                            pix_stall,
	input  logic [1:0]                      command,
	input  logic [lbp_hist_pkg::PIX_W-1:0]  red,
	input  logic [lbp_hist_pkg::PIX_W-1:0]  green,
	input  logic [lbp_hist_pkg::PIX_W-1:0]  blue,
	input  logic [lbp_hist_pkg::BIN_W-1:0]  bin_index,
	input  logic [lbp_hist_pkg::CFG_W-1:0]  cfg_width,
	input  logic [lbp_hist_pkg::CFG_W-1:0]  cfg_height,
	input  logic                            init_done,
	input  logic                            q_full,
	output logic                            q_push,
	output lbp_hist_pkg::item_t             q_item,
	output logic [COL_W-1:0]                q_col
);
	import lbp_hist_pkg::*;

	logic [COL_W:0]     width_use;
	logic [ROW_W:0]     height_use;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W:0]     col_a;
	logic [ROW_W:0]     row_a;
	logic [COL_W:0]     col_n;
	logic [ROW_W:0]     row_n;
	logic               interior_c;
	logic               accept;
	cmd_t               cmd_c;
	logic [SUM_W-1:0]   sum_c;
	logic [2*SUM_W-1:0] prod_c;

	logic               f1_vld_q;
	cmd_t               cmd_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic               interior_s1;
	logic [BIN_W-1:0]   bin_s1;
	logic [COL_W-1:0]   col_s1;

	assign cmd_c     = cmd_t'(command);
	assign pix_stall = !init_done || (f1_vld_q && q_full);
	assign accept    = pix_valid && !pix_stall;
	assign q_push    = f1_vld_q && !q_full;

	always_comb begin
		if (cfg_width < CFG_W'(MIN_DIM)) begin
			width_use = (COL_W+1)'(MIN_DIM);
		end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
			width_use = (COL_W+1)'(MAX_WIDTH);
		end else begin
			width_use = (COL_W+1)'(cfg_width);
		end
		if (cfg_height < CFG_W'(MIN_DIM)) begin
			height_use = (ROW_W+1)'(MIN_DIM);
		end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
			height_use = (ROW_W+1)'(MAX_HEIGHT);
		end else begin
			height_use = (ROW_W+1)'(cfg_height);
		end
	end

	always_comb begin
		col_a = {1'b0, col_q};
		row_a = {1'b0, row_q};
		if (col_a >= width_use) begin
			col_a = '0;
			row_a = row_a + (ROW_W+1)'(1);
		end
		if (row_a >= height_use) begin
			row_a = '0;
		end
		interior_c = (row_a >= (ROW_W+1)'(2)) && (col_a >= (COL_W+1)'(2));
		col_n = col_a + (COL_W+1)'(1);
		row_n = row_a;
		if (col_n >= width_use) begin
			col_n = '0;
			row_n = row_a + (ROW_W+1)'(1);
			if (row_n >= height_use) begin
				row_n = '0;
			end
		end
	end

	assign sum_c = SUM_W'(red) * RED_WT + SUM_W'(green) * GREEN_WT
		+ SUM_W'(blue) * BLUE_WT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			f1_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				f1_vld_q <= 1'b1;
				case (cmd_c)
					CMD_PUSH: begin
						col_q <= col_n[COL_W-1:0];
						row_q <= row_n[ROW_W-1:0];
					end
					CMD_CLEAR: begin
						col_q <= '0;
						row_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (q_push) begin
				f1_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= cmd_c;
			sum_s1      <= sum_c;
			interior_s1 <= (cmd_c == CMD_PUSH) && interior_c;
			bin_s1      <= bin_index;
			col_s1      <= col_a[COL_W-1:0];
		end
	end

	assign prod_c = (2*SUM_W)'(sum_s1) * (2*SUM_W)'(GREY_RECIP);

	always_comb begin
		q_item.cmd       = cmd_s1;
		q_item.grey      = prod_c[GREY_SHIFT +: PIX_W];
		q_item.interior  = interior_s1;
		q_item.bin_index = bin_s1;
		q_col            = col_s1;
	end

endmodule

// File: rtl/core/lbp_hist_queue.sv
// ----------------------------------------------------------------------------
// LBP histogram work queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lbp_hist_queue #(
	parameter int DEPTH = lbp_hist_pkg::QUEUE_DEPTH,
	parameter int COL_W = $clog2(lbp_hist_pkg::DEF_MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lbp_hist_pkg::item_t item_in,
	input  logic [COL_W-1:0]    col_in,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output lbp_hist_pkg::item_t item_out,
	output logic [COL_W-1:0]    col_out
);
	import lbp_hist_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W_Q = $clog2(DEPTH + 1);

	item_t              item_q [DEPTH];
	logic [COL_W-1:0]   col_q  [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W_Q-1:0] cnt_q;

	assign full      = (cnt_q == CNT_W_Q'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign item_out  = item_q[rd_q];
	assign col_out   = col_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W_Q'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W_Q'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_q] <= item_in;
			col_q[wr_q]  <= col_in;
		end
	end

endmodule

// File: rtl/core/lbp_hist_back.sv
// ----------------------------------------------------------------------------
// LBP histogram back end
// Line buffers, 3x3 window, pattern, histogram update and result queue.
// ----------------------------------------------------------------------------
module lbp_hist_back #(
	parameter int MAX_WIDTH = lbp_hist_pkg::DEF_MAX_WIDTH,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_vld,
	input  lbp_hist_pkg::item_t   q_item,
	input  logic [COL_W-1:0]      q_col,
	output logic                  q_pop,
	output logic                  init_done,
	output logic                  res_valid,
	input  logic                  res_stall,
	output lbp_hist_pkg::result_t res
);
	import lbp_hist_pkg::*;

	localparam int OPTR_W = $clog2(OUT_DEPTH);
	localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
	localparam int CRED_W = $clog2(OUT_DEPTH + 4);
	localparam int NBINS  = 2 ** BIN_W;

	logic [PIX_W-1:0] line_above [MAX_WIDTH];
	logic [PIX_W-1:0] line_two   [MAX_WIDTH];
	logic [CNT_W-1:0] hist_mem   [NBINS];
	result_t          out_mem    [OUT_DEPTH];

	logic [COL_W-1:0] init_cnt_q;
	logic             init_done_q;

	logic             vld_s1;
	item_t            item_s1;
	logic [COL_W-1:0] col_s1;
	logic [PIX_W-1:0] above_rd_s1;
	logic [PIX_W-1:0] two_rd_s1;

	logic [PIX_W-1:0] win_q [9];

	logic             vld_s2;
	cmd_t             cmd_s2;
	logic             interior_s2;
	logic [BIN_W-1:0] bin_s2;

	logic             vld_s3;
	cmd_t             cmd_s3;
	logic             interior_s3;
	logic [PIX_W-1:0] code_s3;
	logic [CNT_W-1:0] hist_rd_s3;
	logic             rvld_s3;
	logic             fwd_s3;
	logic [CNT_W-1:0] fwd_data_s3;
	logic             zero_s3;

	logic [NBINS-1:0] hist_vld_q;
	logic [CNT_W-1:0] pix_q;

	logic [OPTR_W-1:0] out_wr_q;
	logic [OPTR_W-1:0] out_rd_q;
	logic [OCNT_W-1:0] out_cnt_q;

	logic             lb_we;
	logic [COL_W-1:0] lb_waddr;
	logic [PIX_W-1:0] lb_above_wd;
	logic [PIX_W-1:0] lb_two_wd;
	logic             push_s1;
	logic [PIX_W-1:0] code_c;
	logic [BIN_W-1:0] raddr_c;
	logic [CNT_W-1:0] cur_c;
	logic             hist_we;
	logic [CNT_W-1:0] hist_wd;
	logic             clear_now;
	logic [CNT_W-1:0] pix_next;
	result_t          res_c;
	logic             out_pop;
	logic [CRED_W-1:0] credit_c;

	assign init_done = init_done_q;
	assign credit_c  = CRED_W'(out_cnt_q) + CRED_W'(vld_s1) + CRED_W'(vld_s2)
		+ CRED_W'(vld_s3);
	assign q_pop     = q_vld && init_done_q && (credit_c < CRED_W'(OUT_DEPTH));
	assign push_s1   = vld_s1 && (item_s1.cmd == CMD_PUSH);

	assign lb_we       = !init_done_q || push_s1;
	assign lb_waddr    = init_done_q ? col_s1 : init_cnt_q;
	assign lb_above_wd = init_done_q ? item_s1.grey : '0;
	assign lb_two_wd   = init_done_q ? above_rd_s1 : '0;

	always_ff @(posedge clk) begin
		if (lb_we) begin
			line_above[lb_waddr] <= lb_above_wd;
			line_two[lb_waddr]   <= lb_two_wd;
		end
		above_rd_s1 <= line_above[q_col];
		two_rd_s1   <= line_two[q_col];
	end

	always_ff @(posedge clk) begin
		item_s1 <= q_item;
		col_s1  <= q_col;
		if (push_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= two_rd_s1;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= above_rd_s1;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= item_s1.grey;
		end
		cmd_s2      <= item_s1.cmd;
		interior_s2 <= item_s1.interior;
		bin_s2      <= item_s1.bin_index;
	end

	assign code_c = {win_q[0] >= win_q[4], win_q[1] >= win_q[4], win_q[2] >= win_q[4],
		win_q[3] >= win_q[4], win_q[5] >= win_q[4], win_q[6] >= win_q[4],
		win_q[7] >= win_q[4], win_q[8] >= win_q[4]};
	assign raddr_c = (cmd_s2 == CMD_READ) ? bin_s2 : code_c;

	assign clear_now = vld_s3 && (cmd_s3 == CMD_CLEAR);
	assign hist_we   = vld_s3 && (cmd_s3 == CMD_PUSH) && interior_s3;
	assign cur_c     = zero_s3 ? '0 : (fwd_s3 ? fwd_data_s3 : (rvld_s3 ? hist_rd_s3 : '0));
	assign hist_wd   = sat_inc(cur_c);

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[code_s3] <= hist_wd;
		end
		hist_rd_s3  <= hist_mem[raddr_c];
		rvld_s3     <= hist_vld_q[raddr_c];
		fwd_s3      <= hist_we && (code_s3 == raddr_c);
		fwd_data_s3 <= hist_wd;
		zero_s3     <= clear_now;
		cmd_s3      <= cmd_s2;
		interior_s3 <= interior_s2;
		code_s3     <= code_c;
	end

	always_comb begin
		res_c    = '0;
		pix_next = pix_q;
		case (cmd_s3)
			CMD_PUSH: begin
				if (interior_s3) begin
					res_c.code_valid = 1'b1;
					res_c.lbp_code   = code_s3;
					pix_next         = sat_inc(pix_q);
				end
			end
			CMD_READ: begin
				res_c.bin_count = sat_out(cur_c);
			end
			CMD_CLEAR: begin
				pix_next = '0;
			end
			default: begin
			end
		endcase
		res_c.interior_count = sat_out(pix_next);
	end

	assign res_valid = (out_cnt_q != '0);
	assign res       = out_mem[out_rd_q];
	assign out_pop   = res_valid && !res_stall;

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			out_mem[out_wr_q] <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q  <= '0;
			init_done_q <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			hist_vld_q  <= '0;
			pix_q       <= '0;
			out_wr_q    <= '0;
			out_rd_q    <= '0;
			out_cnt_q   <= '0;
		end else begin
			if (!init_done_q) begin
				init_cnt_q <= init_cnt_q + COL_W'(1);
				if (init_cnt_q == COL_W'(MAX_WIDTH - 1)) begin
					init_done_q <= 1'b1;
				end
			end
			vld_s1 <= q_pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (clear_now) begin
				hist_vld_q <= '0;
			end else if (hist_we) begin
				hist_vld_q[code_s3] <= 1'b1;
			end
			if (vld_s3) begin
				pix_q    <= pix_next;
				out_wr_q <= (out_wr_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : out_wr_q + OPTR_W'(1);
			end
			if (out_pop) begin
				out_rd_q <= (out_rd_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : out_rd_q + OPTR_W'(1);
			end
			if (vld_s3 && !out_pop) begin
				out_cnt_q <= out_cnt_q + OCNT_W'(1);
			end else if (out_pop && !vld_s3) begin
				out_cnt_q <= out_cnt_q - OCNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/lbp_histogram_core.sv
// ----------------------------------------------------------------------------
// LBP histogram core
// 3x3 local binary pattern texture histogram over an RGB pixel stream.
// ----------------------------------------------------------------------------
// Each input beat carries a command: pixel push, bin read, or clear and start
// a new frame. Pixels arrive in raster order and are turned into grey levels.
// Every input beat yields exactly one result beat, in order. A push that
// completes an interior 3x3 window reports its pattern and bumps its bin; a
// read reports the requested bin; every result carries the interior pixel
// count of the frame so far.
// The block takes one beat per cycle while pix_stall is low. The rate is set
// by the single write port of each line buffer and the histogram
// read-modify-write loop, both of which run once per cycle with forwarding
// between back-to-back updates. After reset the line buffers are cleared and
// pix_stall stays high meanwhile. Image width and height are set over the APB
// port; the user must set them only while the block is idle, which the block
// does not enforce. When the receiver holds res_stall, results collect in an
// eight-entry queue; pix_stall rises once the internal queues fill.
// ----------------------------------------------------------------------------
module lbp_histogram_core #(
	parameter int MAX_WIDTH  = lbp_hist_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lbp_hist_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lbp_hist_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [lbp_hist_pkg::PDATA_W-1:0]    pwdata,
	output logic [lbp_hist_pkg::PDATA_W-1:0]    prdata,
	output logic                                pready,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  logic [1:0]                          command,
	input  logic [lbp_hist_pkg::PIX_W-1:0]      red,
	input  logic [lbp_hist_pkg::PIX_W-1:0]      green,
	input  logic [lbp_hist_pkg::PIX_W-1:0]      blue,
	input  logic [lbp_hist_pkg::BIN_W-1:0]      bin_index,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                code_valid,
	output logic [lbp_hist_pkg::PIX_W-1:0]      lbp_code,
	output logic [lbp_hist_pkg::OUT_CNT_W-1:0]  bin_count,
	output logic [lbp_hist_pkg::OUT_CNT_W-1:0]  interior_count
);
	import lbp_hist_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             cfg_wr;
	reg_sel_t         reg_sel;

	logic             init_done;
	logic             q_full;
	logic             q_push;
	item_t            f_item;
	logic [COL_W-1:0] f_col;
	logic             q_pop;
	logic             q_vld;
	item_t            b_item;
	logic [COL_W-1:0] b_col;
	result_t          res;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = reg_sel_t'(paddr[2]);

	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lbp_hist_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.COL_W      (COL_W),
		.ROW_W      (ROW_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.command    (command),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.bin_index  (bin_index),
		.cfg_width  (width_q),
		.cfg_height (height_q),
		.init_done  (init_done),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (f_item),
		.q_col      (f_col)
	);

	lbp_hist_queue #(
		.DEPTH (QUEUE_DEPTH),
		.COL_W (COL_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.item_in   (f_item),
		.col_in    (f_col),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_vld),
		.item_out  (b_item),
		.col_out   (b_col)
	);

	lbp_hist_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_vld     (q_vld),
		.q_item    (b_item),
		.q_col     (b_col),
		.q_pop     (q_pop),
		.init_done (init_done),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign code_valid     = res.code_valid;
	assign lbp_code       = res.lbp_code;
	assign bin_count      = res.bin_count;
	assign interior_count = res.interior_count;

endmodule

// File: rtl/core/lbp_hist_checker.sv
// ----------------------------------------------------------------------------
// LBP histogram checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module lbp_hist_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                res_valid,
	input logic                                res_stall,
	input logic                                code_valid,
	input logic [lbp_hist_pkg::PIX_W-1:0]      lbp_code,
	input logic [lbp_hist_pkg::OUT_CNT_W-1:0]  bin_count,
	input logic [lbp_hist_pkg::OUT_CNT_W-1:0]  interior_count
);
	import lbp_hist_pkg::*;

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("Result beat dropped while stalled.");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(code_valid) && $stable(lbp_code)
			&& $stable(bin_count) && $stable(interior_count))
		else $error("Stalled result beat changed.");

	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !code_valid |-> lbp_code == '0)
		else $error("Pattern reported without a completed window.");

	a_bin_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> bin_count <= interior_count)
		else $error("Bin count exceeds interior pixel count.");

endmodule

bind lbp_histogram_core lbp_hist_checker u_lbp_hist_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.code_valid     (code_valid),
	.lbp_code       (lbp_code),
	.bin_count      (bin_count),
	.interior_count (interior_count)
);
